@@ src/fbt_pkg.sv @@
// Shared types, constants and codes of the flow batch totalizer.
`default_nettype none
package fbt_pkg;

    localparam int unsigned VAL_W  = 32;   // Q16.16 values and quotients
    localparam int unsigned DEN_W  = 48;   // widest divisor: elapsed_ms * K
    localparam int unsigned CNT_W  = 5;    // quotient bit counter, VAL_W steps
    localparam int unsigned DIVR_W = 16;   // overrun divisor register

    localparam logic [VAL_W-1:0] SAT_VAL = '1;

    // Stream command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_KFACT    = 2'd0;
    localparam logic [1:0] REG_SETPOINT = 2'd1;
    localparam logic [1:0] REG_PRESTOP  = 2'd2;
    localparam logic [1:0] REG_DIVISOR  = 2'd3;

    // Register reset values
    localparam logic [VAL_W-1:0]  RST_KFACT    = 32'd32768000;
    localparam logic [VAL_W-1:0]  RST_SETPOINT = 32'd6553600;
    localparam logic [VAL_W-1:0]  RST_PRESTOP  = 32'd52429;
    localparam logic [DIVR_W-1:0] RST_DIVISOR  = 16'd10;

    typedef struct packed {
        logic [VAL_W-1:0]  kfact;
        logic [VAL_W-1:0]  setpoint;
        logic [VAL_W-1:0]  prestop;
        logic [DIVR_W-1:0] divisor;
    } t_cfg;

    // Dividend is {num_hi, num_lo}; quotient saturates to VAL_W bits.
    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] num_hi;
        logic [VAL_W-1:0] num_lo;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quot;
    } t_div_rsp;

endpackage
`default_nettype wire

@@ src/fbt_regs.sv @@
// APB register file holding the meter and batch configuration.
`default_nettype none
module fbt_regs
    import fbt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kfact    <= RST_KFACT;
            r_cfg.setpoint <= RST_SETPOINT;
            r_cfg.prestop  <= RST_PRESTOP;
            r_cfg.divisor  <= RST_DIVISOR;
        end else if (wr_en) begin
            unique case (idx)
                REG_KFACT:    r_cfg.kfact    <= pwdata;
                REG_SETPOINT: r_cfg.setpoint <= pwdata;
                REG_PRESTOP:  r_cfg.prestop  <= pwdata;
                REG_DIVISOR:  r_cfg.divisor  <= pwdata[DIVR_W-1:0];
                default:      r_cfg.kfact    <= r_cfg.kfact;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_KFACT:    prdata = r_cfg.kfact;
            REG_SETPOINT: prdata = r_cfg.setpoint;
            REG_PRESTOP:  prdata = r_cfg.prestop;
            REG_DIVISOR:  prdata = {{(32-DIVR_W){1'b0}}, r_cfg.divisor};
            default:      prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ src/fbt_div.sv @@
// Shared restoring divider, one quotient bit per cycle, saturating result.
`default_nettype none
module fbt_div
    import fbt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_div_req  i_req,
    output t_div_rsp  o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [VAL_W-1:0] r_q;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // Shift in the next dividend bit and try a subtract.
    assign trial = {r_rem, r_q[VAL_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if ((i_req.num_hi == '0) && (i_req.num_lo == '0)) begin
                    r_q    <= '0;
                    r_done <= 1'b1;
                end else if (i_req.num_hi >= i_req.den) begin
                    // quotient does not fit, also covers a zero divisor
                    r_q    <= SAT_VAL;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= i_req.num_hi;
                    r_q    <= i_req.num_lo;
                    r_den  <= i_req.den;
                    r_cnt  <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_q   <= {r_q[VAL_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule
`default_nettype wire

@@ src/flow_batch_totalizer_top.sv @@
// Top level of the flow batch totalizer: stream ports, sequencer, batch state.
//
// Usage: one item enters on the s_axis side per meter tick or batch command.
// s_axis_tuser carries the command (tick, start, stop); s_axis_tdata carries
// pulse count, elapsed milliseconds, valve and auto-mode flags. Every item
// gives exactly one result transfer on the m_axis side: flow rate, batch total
// after the item, the cutoff flag and the overrun flag.
// A tick runs up to three 32-step divisions (flow rate, tick volume and, in
// overrun, the overrun volume) on one shared divider; a division whose
// dividend is zero or whose quotient clamps skips the bit steps. Start, stop
// and the unused command run no division. The block is ready for the next
// item only once the previous result is parked.
// The result sits in an output register until taken, so the block accepts the
// next item while that result waits; a stalled receiver only holds off the
// following result. Reset clears the total and the running flag and loads the
// default meter K factor, setpoint, prestop margin and divisor.
// The user must write registers over the APB port only while the block is idle; the block itself does not enforce it.
`default_nettype none
module flow_batch_totalizer_top
    import fbt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // item stream in
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [15:0] pulse_count, [31:16] elapsed_ms, [32] valve_open, [33] auto_mode
    input  wire logic [39:0] i_s_axis_tdata,
    // [1:0] command
    input  wire logic [1:0]  i_s_axis_tuser,
    // result stream out
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [31:0] flow_rate, [63:32] batch_total, [64] cutoff_fired, [65] in_overrun
    output logic      [71:0] o_m_axis_tdata,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_PREP      = 4'd1;
    localparam logic [3:0] S_RATE_GO   = 4'd2;
    localparam logic [3:0] S_RATE_WAIT = 4'd3;
    localparam logic [3:0] S_VOL_GO    = 4'd4;
    localparam logic [3:0] S_VOL_WAIT  = 4'd5;
    localparam logic [3:0] S_EVAL      = 4'd6;
    localparam logic [3:0] S_XTRA_GO   = 4'd7;
    localparam logic [3:0] S_XTRA_WAIT = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [3:0]       r_state;
    logic [1:0]       r_cmd;
    logic [15:0]      r_pulses;
    logic [15:0]      r_ms;
    logic             r_valve;
    logic             r_auto;
    logic [DEN_W-1:0] r_hi;
    logic [VAL_W-1:0] r_lo;
    logic [DEN_W-1:0] r_den;
    logic [VAL_W-1:0] r_rate;
    logic [VAL_W-1:0] r_vol;
    logic [VAL_W-1:0] r_total;
    logic             r_running;
    logic             r_cut;
    logic             r_over;
    logic             r_m_valid;
    logic [71:0]      r_m_data;

    logic             in_xfer;
    logic             out_load;
    logic [VAL_W-1:0] thr;
    logic             over_now;
    logic [VAL_W-1:0] eval_add;
    logic [VAL_W-1:0] eval_total;
    logic [35:0]      vol_x10;
    logic [DEN_W-1:0] k60;

    fbt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fbt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    function automatic logic [VAL_W-1:0] add_sat(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VAL_W] ? SAT_VAL : s[VAL_W-1:0];
    endfunction

    assign div_req.start  = (r_state == S_RATE_GO) || (r_state == S_VOL_GO) ||
                            (r_state == S_XTRA_GO);
    assign div_req.num_hi = r_hi;
    assign div_req.num_lo = r_lo;
    assign div_req.den    = r_den;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load = (r_state == S_DONE) && (!r_m_valid || i_m_axis_tready);

    // Threshold floors at zero when the margin exceeds the setpoint.
    assign thr      = (cfg.setpoint > cfg.prestop) ? (cfg.setpoint - cfg.prestop) : '0;
    assign over_now = r_valve && r_auto && (r_total >= thr);
    // In overrun only a running batch adds the plain volume once.
    assign eval_add = (!over_now || r_running) ? r_vol : '0;
    // zero divisor: overrun addition pins the total
    assign eval_total = (over_now && (cfg.divisor == '0)) ? SAT_VAL
                                                          : add_sat(r_total, eval_add);
    assign vol_x10  = {r_vol, 3'b000} + {3'b000, r_vol, 1'b0};
    // 60*K as 64*K - 4*K
    assign k60      = {10'd0, cfg.kfact, 6'd0} - {14'd0, cfg.kfact, 2'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_running <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cmd    <= i_s_axis_tuser;
                        r_pulses <= i_s_axis_tdata[15:0];
                        r_ms     <= i_s_axis_tdata[31:16];
                        r_valve  <= i_s_axis_tdata[32];
                        r_auto   <= i_s_axis_tdata[33];
                        r_state  <= S_PREP;
                    end
                end
                S_PREP: begin
                    // Clear the result flags, then branch on the command.
                    r_rate <= '0;
                    r_cut  <= 1'b0;
                    r_over <= 1'b0;
                    r_hi   <= DEN_W'(r_pulses) * DEN_W'(1000);
                    r_lo   <= '0;
                    r_den  <= DEN_W'(r_ms) * DEN_W'(cfg.kfact);
                    priority case (r_cmd)
                        CMD_TICK: begin
                            r_state <= S_RATE_GO;
                        end
                        CMD_START: begin
                            r_total   <= '0;
                            r_running <= 1'b1;
                            r_state   <= S_DONE;
                        end
                        CMD_STOP: begin
                            r_running <= 1'b0;
                            r_state   <= S_DONE;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_RATE_GO: begin
                    r_state <= S_RATE_WAIT;
                end
                S_RATE_WAIT: begin
                    if (div_rsp.done) begin
                        r_rate  <= div_rsp.quot;
                        r_hi    <= {{(DEN_W-16){1'b0}}, r_pulses};
                        r_lo    <= '0;
                        r_den   <= k60;
                        r_state <= S_VOL_GO;
                    end
                end
                S_VOL_GO: begin
                    r_state <= S_VOL_WAIT;
                end
                S_VOL_WAIT: begin
                    if (div_rsp.done) begin
                        r_vol   <= div_rsp.quot;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_over  <= over_now;
                    r_total <= eval_total;
                    r_hi    <= {{(DEN_W-4){1'b0}}, vol_x10[35:32]};
                    r_lo    <= vol_x10[31:0];
                    r_den   <= {{(DEN_W-DIVR_W){1'b0}}, cfg.divisor};
                    if (over_now) begin
                        if (r_running) begin
                            r_running <= 1'b0;
                            r_cut     <= 1'b1;
                        end
                        if (cfg.divisor == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_XTRA_GO;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_XTRA_GO: begin
                    r_state <= S_XTRA_WAIT;
                end
                S_XTRA_WAIT: begin
                    if (div_rsp.done) begin
                        r_total <= add_sat(r_total, div_rsp.quot);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Park the result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {6'd0, r_over, r_cut, r_total, r_rate};
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule
`default_nettype wire

@@ tb/sv/flow_batch_totalizer_top_tb.sv @@
// Self-checking stream testbench for the flow batch totalizer: directed and random batches.
`timescale 1ns / 1ps

module flow_batch_totalizer_top_tb;
    import fbt_pkg::*;

    // Unused command code; the block must treat it as a no-op
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off under pressure
    localparam int DRAIN_PAUSE  = 150;     // longer than the worst overrun tick latency
    localparam int RAND_PHASES  = 13;
    localparam int PHASE_ITEMS  = 95;
    localparam int QUIET_PHASE  = 4;       // phase that runs with no idling on either side

    typedef struct packed {
        logic [1:0]  cmd;
        logic        auto_on;
        logic        valve;
        logic [15:0] ms;
        logic [15:0] pulses;
    } meter_item_t;

    // Laid out exactly like o_m_axis_tdata[65:0]
    typedef struct packed {
        logic        in_overrun;
        logic        cutoff;
        logic [31:0] batch_total;
        logic [31:0] flow_rate;
    } reading_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [39:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        s_ready;
    logic        m_valid;
    logic [71:0] m_data;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the registers and the batch state
    logic [31:0] k_factor;
    logic [31:0] sp_level;
    logic [31:0] pre_margin;
    logic [15:0] over_div;
    logic [31:0] acc_total;
    logic        batch_open;

    reading_t    readings_due[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          no_idle = 1'b0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          stall_left = 0;

    flow_batch_totalizer_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** flow_batch_totalizer_top: FAILED **");
            $finish;
        end
    end

    // Quotient clamped to 32 bits; a zero divisor saturates unless the dividend is zero
    function automatic logic [31:0] quot_sat(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        if (den == 64'd0) return (num == 64'd0) ? 32'd0 : SAT_VAL;
        q = num / den;
        return (q > 64'hFFFF_FFFF) ? SAT_VAL : q[31:0];
    endfunction

    function automatic logic [31:0] sum_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SAT_VAL : s[31:0];
    endfunction

    // Advance the batch state by one accepted item and return the reading it must produce
    function automatic reading_t meter_step(input meter_item_t it);
        reading_t    r;
        logic [63:0] k;
        logic [31:0] vol;
        logic [31:0] thr;
        logic [31:0] extra;
        r = '0;
        k = {32'd0, k_factor};
        if (it.cmd == CMD_TICK) begin
            r.flow_rate = quot_sat(({48'd0, it.pulses} * 64'd1000) << 32, {48'd0, it.ms} * k);
            vol = quot_sat({16'd0, it.pulses, 32'd0}, 64'd60 * k);
            // a margin above the setpoint pulls the threshold down to zero
            thr = (sp_level > pre_margin) ? sp_level - pre_margin : 32'd0;
            r.in_overrun = it.valve && it.auto_on && (acc_total >= thr);
            if (r.in_overrun) begin
                if (batch_open) begin
                    // cutoff: end the batch and book this tick's volume once
                    batch_open = 1'b0;
                    r.cutoff = 1'b1;
                    acc_total = sum_sat(acc_total, vol);
                end
                extra = (over_div == 16'd0) ? SAT_VAL
                                            : quot_sat({32'd0, vol} * 64'd10, {48'd0, over_div});
                acc_total = sum_sat(acc_total, extra);
            end else begin
                acc_total = sum_sat(acc_total, vol);
            end
        end else if (it.cmd == CMD_START) begin
            acc_total = 32'd0;
            batch_open = 1'b1;
        end else if (it.cmd == CMD_STOP) begin
            batch_open = 1'b0;
        end
        r.batch_total = acc_total;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare every result transfer against the oldest pending reading
    always @(posedge i_clk) begin : result_check
        reading_t want;
        reading_t got;
        if (i_rst_n && m_valid === 1'b1 && m_ready) begin
            got = m_data[65:0];
            if (readings_due.size() == 0) begin
                $error("result transfer with no reading pending: tdata 0x%018h", m_data);
                mismatches++;
            end else begin
                want = readings_due.pop_front();
                check_field("flow_rate", want.flow_rate, got.flow_rate);
                check_field("batch_total", want.batch_total, got.batch_total);
                check_field("cutoff_fired", {31'd0, want.cutoff}, {31'd0, got.cutoff});
                check_field("in_overrun", {31'd0, want.in_overrun}, {31'd0, got.in_overrun});
            end
        end
    end

    // Receiver: random stalls, a quiet stretch, and a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready = 1'b0;
        end else begin
            m_ready = no_idle || ($urandom_range(99) >= 14);
        end
    end

    // Offer one item, hold it until the transfer, then book its expected reading
    task automatic send_reading(input logic [1:0] cmd, input logic [15:0] pulses,
                                input logic [15:0] ms, input logic valve, input logic auto_on);
        meter_item_t it;
        int          gap;
        it = '{cmd: cmd, auto_on: auto_on, valve: valve, ms: ms, pulses: pulses};
        gap = (!no_idle && $urandom_range(99) < 14) ? $urandom_range(1, 4) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_valid = 1'b0;
        end
        @(negedge i_clk);
        s_valid = 1'b1;
        s_data  = {6'd0, auto_on, valve, ms, pulses};
        s_user  = cmd;
        do @(posedge i_clk); while (s_ready !== 1'b1);
        readings_due.push_back(meter_step(it));
        items_sent++;
    endtask

    // Drop valid and wait until every booked reading has come back
    task automatic drain_results();
        @(negedge i_clk);
        s_valid = 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write: setup phase, then access phase; predictor follows at the write edge
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_KFACT:    k_factor   = value;
            REG_SETPOINT: sp_level   = value;
            REG_PRESTOP:  pre_margin = value;
            REG_DIVISOR:  over_div   = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Field extremes under the reset configuration
    task automatic test_field_extremes();
        send_reading(CMD_TICK, 16'h0000, 16'hFFFF, 1'b0, 1'b0);
        send_reading(CMD_TICK, 16'hFFFF, 16'h0001, 1'b1, 1'b1);  // flow rate clamps
        send_reading(CMD_TICK, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        send_reading(CMD_TICK, 16'h0001, 16'h0000, 1'b0, 1'b1);  // zero elapsed time
    endtask

    // Start, stop and the unused code: no volume booked, zeroed result fields
    task automatic test_batch_commands();
        send_reading(CMD_START, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        send_reading(CMD_STOP, 16'h1234, 16'h0000, 1'b1, 1'b1);
        send_reading(CMD_NONE, 16'hFFFF, 16'h0001, 1'b1, 1'b1);
        send_reading(CMD_TICK, 16'd100, 16'd10, 1'b0, 1'b0);
    endtask

    // K of 1.0, 600 pulses give 10 L per tick: cutoff on the third tick, then pure overrun
    task automatic test_cutoff_and_overrun();
        drain_results();
        write_register(REG_KFACT, 32'd65536);
        write_register(REG_SETPOINT, 32'h0010_0000);
        write_register(REG_PRESTOP, 32'd0);
        write_register(REG_DIVISOR, 32'd1);
        send_reading(CMD_START, 16'd0, 16'd1, 1'b0, 1'b0);
        repeat (4) send_reading(CMD_TICK, 16'd600, 16'd1000, 1'b1, 1'b1);
        send_reading(CMD_TICK, 16'd600, 16'd1000, 1'b0, 1'b1);
        drain_results();
        write_register(REG_KFACT, 32'hFFFF_FFFF);
        send_reading(CMD_TICK, 16'hFFFF, 16'd1, 1'b1, 1'b1);
    endtask

    // Margin above the setpoint cuts off at once; a full-scale setpoint never does
    task automatic test_margin_above_setpoint();
        drain_results();
        write_register(REG_KFACT, RST_KFACT);
        write_register(REG_SETPOINT, RST_SETPOINT);
        write_register(REG_PRESTOP, 32'hFFFF_FFFF);
        write_register(REG_DIVISOR, 32'd65535);
        send_reading(CMD_START, 16'd5, 16'd5, 1'b1, 1'b1);
        send_reading(CMD_TICK, 16'hFFFF, 16'd40, 1'b1, 1'b1);
        send_reading(CMD_TICK, 16'hFFFF, 16'd40, 1'b1, 1'b1);
        drain_results();
        write_register(REG_SETPOINT, 32'hFFFF_FFFF);
        write_register(REG_PRESTOP, 32'd0);
        send_reading(CMD_TICK, 16'hFFFF, 16'd40, 1'b1, 1'b1);
    endtask

    // Zero K factor: both quotients clamp unless no pulses arrived
    task automatic test_zero_kfactor();
        drain_results();
        write_register(REG_KFACT, 32'd0);
        send_reading(CMD_TICK, 16'd0, 16'd5, 1'b0, 1'b0);
        send_reading(CMD_TICK, 16'd7, 16'd5, 1'b0, 1'b0);
    endtask

    // Zero divisor: the overrun addition clamps the total even with no pulses
    task automatic test_zero_divisor();
        drain_results();
        write_register(REG_KFACT, 32'd655360);
        write_register(REG_SETPOINT, 32'd0);
        write_register(REG_PRESTOP, 32'd0);
        write_register(REG_DIVISOR, 32'hABCD_0000);  // upper bits must be dropped
        send_reading(CMD_START, 16'd0, 16'd1, 1'b0, 1'b0);
        send_reading(CMD_TICK, 16'd60, 16'd100, 1'b1, 1'b1);
        send_reading(CMD_TICK, 16'd0, 16'd100, 1'b1, 1'b1);
    endtask

    // Hold the receiver off while items keep coming, so the input side backs up
    task automatic test_output_backpressure();
        drain_results();
        write_register(REG_KFACT, RST_KFACT);
        write_register(REG_SETPOINT, RST_SETPOINT);
        write_register(REG_PRESTOP, RST_PRESTOP);
        write_register(REG_DIVISOR, 32'd10);
        hold_requests++;
        send_reading(CMD_START, 16'd0, 16'd1, 1'b0, 1'b0);
        repeat (19) send_reading(CMD_TICK, 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(1, 65535)), 1'b1, 1'b1);
    endtask

    // Random configurations, each driving well-formed batches with some command noise
    task automatic test_random_batches();
        int unsigned r;
        int          base;
        int          n;
        logic [31:0] k;
        logic [63:0] per_tick;
        logic [63:0] sp;
        logic [31:0] margin;
        logic [31:0] div_word;
        logic [1:0]  cmd;
        logic [15:0] pulses;
        logic [15:0] ms;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            drain_results();
            no_idle = (phase == QUIET_PHASE);

            // pick K so batches reach the setpoint within a few dozen ticks
            r = $urandom_range(99);
            if (r < 55)      k = $urandom_range(65536, 65536 * 600);
            else if (r < 75) k = $urandom_range(65536, 65536 * 20);
            else if (r < 88) k = $urandom_range(65536, 32'hFFFF_FFFF);
            else if (r < 94) k = 32'hFFFF_FFFF;
            else             k = 32'd65536;
            per_tick = (64'd32768 << 32) / (64'd60 * {32'd0, k});
            sp = per_tick * 64'($urandom_range(1, 30));
            if (sp > 64'hFFFF_FFFF || $urandom_range(99) < 8) sp = {32'd0, $urandom()};
            r = $urandom_range(99);
            if (r < 70)      margin = $urandom_range(0, sp[31:0] / 8);
            else if (r < 85) margin = 32'd0;
            else             margin = $urandom();
            r = $urandom_range(99);
            if (r < 40)      div_word = $urandom_range(1, 20);
            else if (r < 80) div_word = $urandom_range(1, 65535);
            else if (r < 90) div_word = 32'd65535;
            else             div_word = 32'd1;
            div_word[31:16] = 16'($urandom_range(0, 65535));

            write_register(REG_KFACT, k);
            write_register(REG_SETPOINT, sp[31:0]);
            write_register(REG_PRESTOP, margin);
            write_register(REG_DIVISOR, div_word);

            base = items_sent;
            while (items_sent - base < PHASE_ITEMS) begin
                n = $urandom_range(4, 40);
                send_reading(CMD_START, 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
                repeat (n) begin
                    r = $urandom_range(99);
                    if (r < 4)      cmd = CMD_STOP;
                    else if (r < 7) cmd = CMD_START;
                    else if (r < 9) cmd = CMD_NONE;
                    else            cmd = CMD_TICK;
                    pulses = ($urandom_range(99) < 20) ? 16'($urandom_range(0, 15))
                                                       : 16'($urandom_range(0, 65535));
                    ms = ($urandom_range(99) < 15) ? 16'($urandom_range(0, 20))
                                                   : 16'($urandom_range(0, 65535));
                    send_reading(cmd, pulses, ms, $urandom_range(99) < 90,
                                 $urandom_range(99) < 90);
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        k_factor   = RST_KFACT;
        sp_level   = RST_SETPOINT;
        pre_margin = RST_PRESTOP;
        over_div   = RST_DIVISOR;
        acc_total  = 32'd0;
        batch_open = 1'b0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_field_extremes();
        test_batch_commands();
        test_cutoff_and_overrun();
        test_margin_above_setpoint();
        test_zero_kfactor();
        test_zero_divisor();
        test_output_backpressure();
        test_random_batches();

        drain_results();
        repeat (DRAIN_PAUSE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** flow_batch_totalizer_top: PASSED **");
        end else begin
            $display("** flow_batch_totalizer_top: FAILED **");
        end
        $finish;
    end

endmodule

@@ flow_batch_totalizer_top.f @@
src/fbt_pkg.sv
src/fbt_regs.sv
src/fbt_div.sv
src/flow_batch_totalizer_top.sv
tb/sv/flow_batch_totalizer_top_tb.sv
